@@ rtl/core/tdpc_pkg.sv @@
// tdpc_pkg: shared types and constants of the trial-division prime counter
package tdpc_pkg;

  localparam int unsigned WordWidth = 32;

  typedef logic [WordWidth-1:0] word_t;

  typedef struct packed {
    word_t candidate;
    logic  clear_count;
  } in_word_t;

  typedef struct packed {
    word_t tested_value;
    logic  candidate_is_prime;
    word_t prime_count;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_FINISH
  } state_t;

endpackage

@@ rtl/core/tdpc_div.sv @@
// tdpc_div: bit-serial restoring divider, one quotient bit per cycle
module tdpc_div #(
  parameter int unsigned Width = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [Width-1:0] dividend,
  input  logic [Width-1:0] divisor,
  output logic             done,
  output logic [Width-1:0] quotient,
  output logic [Width-1:0] remainder
);

  localparam int unsigned CntWidth = $clog2(Width + 1);

  logic                busy;
  logic [CntWidth-1:0] cnt;
  logic [Width-1:0]    dsr;
  logic [Width:0]      shifted;
  logic [Width:0]      diff;

  // partial remainder with the next dividend bit shifted in
  assign shifted = {remainder, quotient[Width-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntWidth'(Width);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dsr       <= divisor;
    end else if (busy) begin
      if (!diff[Width]) begin
        remainder <= diff[Width-1:0];
        quotient  <= {quotient[Width-2:0], 1'b1};
      end else begin
        remainder <= shifted[Width-1:0];
        quotient  <= {quotient[Width-2:0], 1'b0};
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");

endmodule

@@ rtl/core/trial_division_prime_counter_top.sv @@
// trial_division_prime_counter_top: trial-division primality test with running prime count
// sequence: candidates 0 and 1 go straight from S_IDLE to S_FINISH; otherwise each divisor
//   tried passes through S_START and S_WAIT while the shared serial divider works on NW bits
//   (NW = min(VALUE_WIDTH, 32)); a prime runs until d > n/d, a small factor ends the test sooner
// throughput: one word at a time; in_ready is high only while the sequencer is idle
// reset: synchronous, active high; clears the sequencer, the output valid and the count
module trial_division_prime_counter_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tdpc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tdpc_pkg::out_word_t out_data
);

  // only the low bits of the 32-bit candidate are ever tested
  localparam int unsigned NW = (VALUE_WIDTH < tdpc_pkg::WordWidth) ?
                               VALUE_WIDTH : tdpc_pkg::WordWidth;

  tdpc_pkg::state_t state;
  tdpc_pkg::state_t state_next;

  logic [NW-1:0]       n;        // candidate under test
  logic [NW-1:0]       d;        // current trial divisor
  logic                clr;      // clear request carried with the word
  logic                prime;    // verdict, valid in S_FINISH
  tdpc_pkg::word_t     count;    // primes seen since last clear
  tdpc_pkg::word_t     count_next;

  logic                in_fire;
  logic                out_load;
  logic                div_start;
  logic                div_done;
  logic [NW-1:0]       div_q;
  logic [NW-1:0]       div_r;
  logic [NW-1:0]       cand;
  logic                cand_small;
  logic                past_bound;  // d > n/d, no divisor left to try
  logic                exact;       // d divides n

  assign cand       = in_data.candidate[NW-1:0];
  assign cand_small = (cand < NW'(2));
  assign past_bound = (d > div_q);
  assign exact      = (div_r == '0);
  assign in_fire    = in_valid && in_ready;

  // shared divider: one n / d per divisor, quotient for the bound, remainder for the test
  tdpc_div #(
    .Width (NW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (n),
    .divisor   (d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tdpc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = cand_small ? tdpc_pkg::S_FINISH : tdpc_pkg::S_START;
        end
      end
      tdpc_pkg::S_START: begin
        state_next = tdpc_pkg::S_WAIT;
      end
      tdpc_pkg::S_WAIT: begin
        if (div_done) begin
          state_next = (past_bound || exact) ? tdpc_pkg::S_FINISH : tdpc_pkg::S_START;
        end
      end
      tdpc_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = tdpc_pkg::S_IDLE;
        end
      end
      default: state_next = tdpc_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      tdpc_pkg::S_IDLE:   in_ready  = 1'b1;
      tdpc_pkg::S_START:  div_start = 1'b1;
      tdpc_pkg::S_WAIT:   ;
      tdpc_pkg::S_FINISH: out_load  = !out_valid || out_ready;
      default:            ;
    endcase
  end

  // count after this word: cleared first if asked, then bumped on a prime
  assign count_next = (clr ? '0 : count) + tdpc_pkg::word_t'(prime);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdpc_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      n     <= cand;
      d     <= NW'(2);
      clr   <= in_data.clear_count;
      prime <= 1'b0;
    end else if (state == tdpc_pkg::S_WAIT && div_done) begin
      if (past_bound) begin
        prime <= 1'b1;
      end else if (!exact) begin
        d <= d + 1'b1;
      end
    end
  end

  // output register, holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.tested_value       <= tdpc_pkg::word_t'(n);
      out_data.candidate_is_prime <= prime;
      out_data.prime_count        <= count_next;
    end
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state != tdpc_pkg::S_IDLE)
    else $error("accepted word did not start a test");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == tdpc_pkg::S_WAIT)
    else $error("divider finished outside the wait state");
  a_divisor_min: assert property (@(posedge clk) disable iff (rst)
    (state == tdpc_pkg::S_START || state == tdpc_pkg::S_WAIT) |-> d >= NW'(2))
    else $error("trial divisor below two");
  a_count_bump: assert property (@(posedge clk) disable iff (rst)
    (out_load && prime && !clr) |=> count == $past(count) + 1'b1)
    else $error("prime count not advanced on a prime");

endmodule
